// ===== rtl/tccs_pkg.sv =====
// Shared constants and controller/datapath interface types for the text console unit.
`timescale 1ns / 1ps

package tccs_pkg;

    localparam int COLUMNS_DEFAULT = 80;
    localparam int ROWS_DEFAULT    = 25;

    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = 16;
    localparam int ROWFLD_W  = 5;
    localparam int COLFLD_W  = 7;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
    localparam logic [CHAR_W-1:0] BYTE_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] BYTE_LF    = 8'd10;

    // Commands from the controller to the datapath, one step each.
    typedef struct packed {
        logic capture;
        logic wrap;
        logic put_char;
        logic read;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic mode;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/tccs_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
`timescale 1ns / 1ps

module tccs_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  tccs_pkg::dp_stat_t stat,
    output tccs_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_CHAR  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START: begin
                // A read only needs the memory access; a put first settles a full line.
                if (stat.mode) begin
                    cmd.read   = 1'b1;
                    state_next = S_DONE;
                end else begin
                    cmd.wrap   = 1'b1;
                    state_next = S_CHAR;
                end
            end
            S_CHAR: begin
                cmd.put_char = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tccs_datapath.sv =====
// Datapath: cursor, row ring with fill counts, cell memory and output register.
`timescale 1ns / 1ps

module tccs_datapath #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tccs_pkg::ROWS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [tccs_pkg::ATTR_W-1:0]      cfg_data,
    input  logic [tccs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [tccs_pkg::M_TDATA_W-1:0]   m_tdata,
    input  tccs_pkg::dp_cmd_t                cmd,
    output tccs_pkg::dp_stat_t               stat
);

    localparam int CW       = $clog2(COLUMNS + 1);
    localparam int RW       = $clog2(ROWS);
    localparam int DEPTH    = ROWS * COLUMNS;
    localparam int AW       = $clog2(DEPTH);
    localparam int CHAR_W   = tccs_pkg::CHAR_W;
    localparam int ROWFLD_W = tccs_pkg::ROWFLD_W;
    localparam int COLFLD_W = tccs_pkg::COLFLD_W;
    localparam int CELL_W   = tccs_pkg::CELL_W;
    localparam int PAD_W    = tccs_pkg::M_TDATA_W - CELL_W - COLFLD_W - ROWFLD_W - 1;

    localparam logic [RW:0]   ROWS_EXT  = (RW + 1)'(ROWS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COLS_FULL = CW'(COLUMNS);

    // Request fields
    logic                 mode_reg;
    logic [CHAR_W-1:0]    char_reg;
    logic [ROWFLD_W-1:0]  rrow_reg;
    logic [COLFLD_W-1:0]  rcol_reg;

    logic [tccs_pkg::ATTR_W-1:0] attr_reg;

    // Cursor and ring of physical rows; top_reg is the physical row shown on top.
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] line_reg, line_next;
    logic [RW-1:0] top_reg, top_next;
    logic [CW-1:0] fill_reg [ROWS];
    logic [CW-1:0] fill_next [ROWS];

    logic              scrolled_reg, scrolled_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic              hit_reg;
    logic [CELL_W-1:0] mem_q;
    logic [CELL_W-1:0] mem [DEPTH];

    logic                          m_tvalid_reg;
    logic [tccs_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic [RW-1:0]     cur_phys, read_phys, fill_idx, addr_row;
    logic [CW-1:0]     fill_sel;
    logic [AW-1:0]     mem_addr;
    logic              mem_we;
    logic              is_cr, is_lf, do_nl, read_ok;
    logic [CELL_W-1:0] out_cell;

    function automatic logic [RW-1:0] to_phys(input logic [RW-1:0] lrow,
                                              input logic [RW-1:0] top);
        logic [RW:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= ROWS_EXT) begin
            sum = sum - ROWS_EXT;
        end
        return sum[RW-1:0];
    endfunction

    assign cur_phys  = to_phys(line_reg, top_reg);
    assign read_phys = to_phys(RW'(rrow_reg), top_reg);
    assign fill_idx  = cmd.read ? read_phys : cur_phys;
    assign fill_sel  = fill_reg[fill_idx];
    assign addr_row  = cmd.read ? read_phys : cur_phys;
    assign mem_addr  = cmd.read ? AW'(int'(addr_row) * COLUMNS + int'(rcol_reg))
                                : AW'(int'(addr_row) * COLUMNS + int'(col_reg));

    assign is_cr   = (char_reg == tccs_pkg::BYTE_CR);
    assign is_lf   = (char_reg == tccs_pkg::BYTE_LF);
    assign do_nl   = (cmd.wrap && (col_reg >= COLS_FULL)) || (cmd.put_char && is_lf);
    assign mem_we  = cmd.put_char && !is_cr && !is_lf;
    // Cells at or past a row's fill count were never written since the row was cleared.
    assign read_ok = (int'(rrow_reg) < ROWS) && (int'(rcol_reg) < COLUMNS)
                     && (int'(rcol_reg) < int'(fill_sel));

    always_comb begin
        col_next      = col_reg;
        line_next     = line_reg;
        top_next      = top_reg;
        fill_next     = fill_reg;
        scrolled_next = scrolled_reg;
        cell_next     = cell_reg;
        if (cmd.capture) begin
            scrolled_next = 1'b0;
            cell_next     = '0;
        end
        if (do_nl) begin
            col_next = '0;
            if (line_reg == LAST_ROW) begin
                // Scroll: the old top row becomes the cleared bottom row.
                top_next          = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                fill_next[top_reg] = '0;
                scrolled_next     = 1'b1;
            end else begin
                line_next = line_reg + 1'b1;
            end
        end
        if (cmd.put_char && is_cr) begin
            col_next = '0;
        end
        if (mem_we) begin
            cell_next = {attr_reg, char_reg};
            col_next  = col_reg + 1'b1;
            if (col_reg == fill_sel) begin
                fill_next[cur_phys] = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= tccs_pkg::ATTR_RESET;
            col_reg  <= '0;
            line_reg <= '0;
            top_reg  <= '0;
            for (int i = 0; i < ROWS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                attr_reg <= cfg_data;
            end
            col_reg  <= col_next;
            line_reg <= line_next;
            top_reg  <= top_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg <= s_tuser[0];
            char_reg <= s_tdata[CHAR_W-1:0];
            rrow_reg <= s_tdata[CHAR_W +: ROWFLD_W];
            rcol_reg <= s_tdata[CHAR_W + ROWFLD_W +: COLFLD_W];
        end
        scrolled_reg <= scrolled_next;
        cell_reg     <= cell_next;
        if (cmd.read) begin
            hit_reg <= read_ok;
        end
    end

    // The read data is held until the result is loaded, also across a stall.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= {attr_reg, char_reg};
        end
        if (cmd.read) begin
            mem_q <= mem[mem_addr];
        end
    end

    assign out_cell = mode_reg ? (hit_reg ? mem_q : '0) : cell_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {PAD_W'(0), scrolled_reg, ROWFLD_W'(line_reg),
                            COLFLD_W'(col_reg), out_cell};
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign stat.mode     = mode_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;

endmodule

// ===== rtl/text_console_cursor_scroll_unit.sv =====
// Top level of the teletype text console: controller plus datapath.
// Usage:
//   Requests enter on the s_ stream channel. s_tuser[0] selects the kind:
//   0 puts a character at the cursor, 1 reads one cell at the given row and
//   column. Every request yields exactly one result on the m_ channel.
//   The attribute byte for written cells is loaded through the cfg_ write
//   channel, which is always ready; write it only while the unit is idle.
//   A put request passes through the controller steps S_START, S_CHAR and
//   S_DONE, a read request through S_START, where the cell memory is read
//   into a register, and S_DONE; S_DONE loads the output register once it
//   is free. One request is worked on at a time.
//   Scrolling rotates a ring of row pointers and zeroes the new bottom row's
//   fill count, so a scroll adds no controller step and no clearing pass.
//   Reset clears the cursor, the row ring, all row fill counts and the
//   output valid, and loads the attribute with 7; the screen reads as blank
//   at once, with no clearing pass.
//   When the receiver stalls, the result waits in the output register and
//   the next request is still accepted; its result waits in the datapath
//   until the register is taken.
`timescale 1ns / 1ps

module text_console_cursor_scroll_unit #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tccs_pkg::ROWS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tccs_pkg::ATTR_W-1:0]      cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // char_code [7:0], read_row [12:8], read_col [19:13], zero [23:20]
    input  logic [tccs_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode [0]
    input  logic [0:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // cell_value [15:0], cursor_col [22:16], cursor_row [27:23], scrolled [28], zero [31:29]
    output logic [tccs_pkg::M_TDATA_W-1:0]   m_tdata
);

    tccs_pkg::dp_cmd_t  cmd;
    tccs_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    tccs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tccs_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== rtl/tccs_checker.sv =====
// Port-level checks for the text console unit, bound to the top level.
`timescale 1ns / 1ps

module tccs_checker #(
    parameter int COLUMNS = tccs_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tccs_pkg::ROWS_DEFAULT
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tccs_pkg::M_TDATA_W-1:0] m_tdata
);

    // The cursor reported with a result always lies on a screen row, its column at most COLUMNS.
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (int'(m_tdata[22:16]) <= COLUMNS) && (int'(m_tdata[27:23]) < ROWS))
        else $error("cursor outside the screen");

    // A scroll leaves the cursor on the bottom row at column 0 or 1.
    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[28]) |-> (int'(m_tdata[27:23]) == ROWS - 1)
                                      && (int'(m_tdata[22:16]) <= 1))
        else $error("scroll reported off the bottom row");

    // No result is shown as valid right after reset.
    a_no_early_result: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // Only one request is worked on at a time.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while one is in progress");

endmodule

bind text_console_cursor_scroll_unit tccs_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tccs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
